// ----- hdl/smt_pkg.sv -----
`default_nettype none
package smt_pkg;

  localparam int COORD_W    = 16;
  localparam int DEN_W      = 16;
  localparam int NUM_W      = 44;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;

  typedef enum logic [1:0] {
    VERDICT_KEPT  = 2'd0,
    VERDICT_VERT  = 2'd1,
    VERDICT_DEPTH = 2'd2
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL     = 3'd0,
    REG_BASELINE  = 3'd1,
    REG_CENTER_U  = 3'd2,
    REG_CENTER_V  = 3'd3,
    REG_MIN_DEPTH = 3'd4,
    REG_MAX_DEPTH = 3'd5,
    REG_MAX_VOFF  = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [COORD_W-1:0] left_u;
    logic [COORD_W-1:0] left_v;
    logic [COORD_W-1:0] right_u;
    logic [COORD_W-1:0] right_v;
  } match_t;

  typedef struct packed {
    verdict_t           verdict;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [29:0]        point_z;
  } point_t;

  typedef struct packed {
    logic [19:0] focal_length;
    logic [23:0] baseline_um;
    logic [15:0] center_u;
    logic [15:0] center_v;
    logic [29:0] min_depth_um;
    logic [29:0] max_depth_um;
    logic [9:0]  max_vertical_offset;
  } cfg_t;

  typedef struct packed {
    verdict_t verdict;
    logic     neg_x;
    logic     neg_y;
  } side_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic [NUM_W-1:0] num_z;
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
    side_t            side;
  } div_word_t;

  typedef struct packed {
    logic [NUM_W-1:0] q_z;
    logic [NUM_W-1:0] q_x;
    logic [NUM_W-1:0] q_y;
    side_t            side;
  } div_result_t;

endpackage
`default_nettype wire

// ----- hdl/stereo_match_triangulate_unit.sv -----
`default_nettype none
// Stereo match triangulator. Each word on the match channel is one left/right
// keypoint pair in unsigned 12.4 pixels; each word on the point channel is its
// verdict (kept, vertical offset too large, depth out of range) and, when
// kept, the point in micrometres: z = baseline * focal / disparity, x and y
// scaled from the principal point and saturated to 32-bit signed. Rejected
// matches carry zero coordinates. The block is fully pipelined: it takes one
// match every cycle while the point channel does not stall, and returns each
// result after four front stages, 44 one-bit restoring divider stages and one
// output register. A stall on the point channel while a point is valid
// freezes the whole pipeline and is echoed on match_stall in the same cycle.
// Configuration registers take writes any time (cfg_ready is always high);
// write them only while no match is in flight.
module stereo_match_triangulate_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              match_valid,
  output logic                                   match_stall,
  input  wire smt_pkg::match_t                   match,
  output logic                                   point_valid,
  input  wire logic                              point_stall,
  output smt_pkg::point_t                        point,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [smt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [smt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import smt_pkg::*;

  cfg_t        cfg;
  logic        advance;
  logic        front_valid;
  div_word_t   front_word;
  logic        div_valid;
  div_result_t div_result;
  point_t      point_next;

  // advance every stage unless a finished word is held by the consumer
  assign advance     = !point_valid || !point_stall;
  assign match_stall = !advance;
  assign cfg_ready   = 1'b1;

  // configuration registers; drop writes beyond the register list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_length        <= 20'd16000;
      cfg.baseline_um         <= 24'd100000;
      cfg.center_u            <= 16'd10240;
      cfg.center_v            <= 16'd7680;
      cfg.min_depth_um        <= 30'd1000;
      cfg.max_depth_um        <= 30'd100000000;
      cfg.max_vertical_offset <= 10'd32;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FOCAL:     cfg.focal_length        <= cfg_data[19:0];
        REG_BASELINE:  cfg.baseline_um         <= cfg_data[23:0];
        REG_CENTER_U:  cfg.center_u            <= cfg_data[15:0];
        REG_CENTER_V:  cfg.center_v            <= cfg_data[15:0];
        REG_MIN_DEPTH: cfg.min_depth_um        <= cfg_data[29:0];
        REG_MAX_DEPTH: cfg.max_depth_um        <= cfg_data[29:0];
        REG_MAX_VOFF:  cfg.max_vertical_offset <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  smt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (match_valid),
    .in_match (match),
    .cfg      (cfg),
    .out_valid(front_valid),
    .out_word (front_word)
  );

  smt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (front_valid),
    .in_word   (front_word),
    .out_valid (div_valid),
    .out_result(div_result)
  );

  // saturate x and y to 32-bit signed, zero everything on a reject
  always_comb begin
    point_next.verdict = div_result.side.verdict;
    point_next.point_x = '0;
    point_next.point_y = '0;
    point_next.point_z = '0;
    if (div_result.side.verdict == VERDICT_KEPT) begin
      point_next.point_z = div_result.q_z[29:0];
      if (div_result.side.neg_x) begin
        point_next.point_x = (|div_result.q_x[NUM_W-1:31]) ? 32'sh8000_0000
                             : 32'(~div_result.q_x[31:0] + 32'd1);
      end else begin
        point_next.point_x = (|div_result.q_x[NUM_W-1:31]) ? 32'sh7FFF_FFFF
                             : 32'(div_result.q_x[31:0]);
      end
      if (div_result.side.neg_y) begin
        point_next.point_y = (|div_result.q_y[NUM_W-1:31]) ? 32'sh8000_0000
                             : 32'(~div_result.q_y[31:0] + 32'd1);
      end else begin
        point_next.point_y = (|div_result.q_y[NUM_W-1:31]) ? 32'sh7FFF_FFFF
                             : 32'(div_result.q_y[31:0]);
      end
    end
  end

  // output register: hold the word while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (advance) begin
      point_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      point <= point_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/smt_front.sv -----
`default_nettype none
module smt_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic              in_valid,
  input  wire smt_pkg::match_t   in_match,
  input  wire smt_pkg::cfg_t     cfg,
  output logic                   out_valid,
  output smt_pkg::div_word_t     out_word
);
  import smt_pkg::*;

  // stage 1: captured match
  logic   s1_valid;
  match_t s1;

  // stage 2: differences, depth numerator
  logic             s2_valid;
  logic             s2_vert_fail;
  logic             s2_dpos;
  logic [DEN_W-1:0] s2_d;
  logic [15:0]      s2_mag_x;
  logic [15:0]      s2_mag_y;
  logic             s2_neg_x;
  logic             s2_neg_y;
  logic [43:0]      s2_num;

  // stage 3: range bounds and coordinate numerators
  logic             s3_valid;
  logic             s3_vert_fail;
  logic             s3_dpos;
  logic [DEN_W-1:0] s3_d;
  logic             s3_neg_x;
  logic             s3_neg_y;
  logic [43:0]      s3_num;
  logic [45:0]      s3_lo;
  logic [45:0]      s3_hi;
  logic [39:0]      s3_px;
  logic [39:0]      s3_py;

  logic [15:0] voff;
  verdict_t    verdict;

  always_comb begin
    voff = (s1.left_v > s1.right_v) ? s1.left_v - s1.right_v : s1.right_v - s1.left_v;
  end

  always_comb begin
    if (s3_vert_fail) begin
      verdict = VERDICT_VERT;
    end else if (!s3_dpos || ({2'b00, s3_num} < s3_lo) || ({2'b00, s3_num} > s3_hi)) begin
      verdict = VERDICT_DEPTH;
    end else begin
      verdict = VERDICT_KEPT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1 <= in_match;

      s2_vert_fail <= voff > {6'd0, cfg.max_vertical_offset};
      s2_dpos      <= s1.left_u > s1.right_u;
      s2_d         <= s1.left_u - s1.right_u;
      s2_neg_x     <= s1.left_u < cfg.center_u;
      s2_neg_y     <= s1.left_v < cfg.center_v;
      s2_mag_x     <= (s1.left_u < cfg.center_u) ? cfg.center_u - s1.left_u
                                                 : s1.left_u - cfg.center_u;
      s2_mag_y     <= (s1.left_v < cfg.center_v) ? cfg.center_v - s1.left_v
                                                 : s1.left_v - cfg.center_v;
      s2_num       <= 44'(cfg.baseline_um) * 44'(cfg.focal_length);

      s3_vert_fail <= s2_vert_fail;
      s3_dpos      <= s2_dpos;
      s3_d         <= s2_d;
      s3_neg_x     <= s2_neg_x;
      s3_neg_y     <= s2_neg_y;
      s3_num       <= s2_num;
      s3_lo        <= 46'(cfg.min_depth_um) * 46'(s2_d);
      s3_hi        <= 46'(cfg.max_depth_um) * 46'(s2_d);
      s3_px        <= 40'(s2_mag_x) * 40'(cfg.baseline_um);
      s3_py        <= 40'(s2_mag_y) * 40'(cfg.baseline_um);

      out_word.den          <= s3_d;
      out_word.num_z        <= s3_num;
      out_word.num_x        <= {4'd0, s3_px};
      out_word.num_y        <= {4'd0, s3_py};
      out_word.side.verdict <= verdict;
      out_word.side.neg_x   <= s3_neg_x;
      out_word.side.neg_y   <= s3_neg_y;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/smt_div.sv -----
`default_nettype none
module smt_div (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                advance,
  input  wire logic                in_valid,
  input  wire smt_pkg::div_word_t  in_word,
  output logic                     out_valid,
  output smt_pkg::div_result_t     out_result
);
  import smt_pkg::*;

  localparam int LANES = 3;

  // one quotient bit per stage, three lanes sharing the divisor
  logic [DEN_W-1:0] rem_q   [NUM_W][LANES];
  logic [NUM_W-1:0] acc_q   [NUM_W][LANES];
  logic [DEN_W-1:0] den_q   [NUM_W];
  side_t            side_q  [NUM_W];
  logic             valid_q [NUM_W];

  logic [NUM_W-1:0] acc_0   [LANES];
  logic [DEN_W-1:0] rem_i   [NUM_W][LANES];
  logic [NUM_W-1:0] acc_i   [NUM_W][LANES];
  logic [DEN_W-1:0] den_i   [NUM_W];
  side_t            side_i  [NUM_W];

  logic [DEN_W:0]   cand  [NUM_W][LANES];
  logic [DEN_W:0]   diff  [NUM_W][LANES];
  logic             ge    [NUM_W][LANES];

  always_comb begin
    acc_0[0] = in_word.num_z;
    acc_0[1] = in_word.num_x;
    acc_0[2] = in_word.num_y;
  end

  // stage inputs: the incoming word for the first stage, the previous
  // stage's registers for the others
  always_comb begin
    for (int k = 0; k < NUM_W; k++) begin
      if (k == 0) begin
        den_i[k]  = in_word.den;
        side_i[k] = in_word.side;
        for (int l = 0; l < LANES; l++) begin
          rem_i[k][l] = '0;
          acc_i[k][l] = acc_0[l];
        end
      end else begin
        den_i[k]  = den_q[k-1];
        side_i[k] = side_q[k-1];
        for (int l = 0; l < LANES; l++) begin
          rem_i[k][l] = rem_q[k-1][l];
          acc_i[k][l] = acc_q[k-1][l];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_W; k++) begin
      for (int l = 0; l < LANES; l++) begin
        cand[k][l] = {rem_i[k][l], acc_i[k][l][NUM_W-1]};
        diff[k][l] = cand[k][l] - {1'b0, den_i[k]};
        ge[k][l]   = cand[k][l] >= {1'b0, den_i[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_W; k++) begin
        valid_q[k] <= 1'b0;
      end
    end else if (advance) begin
      valid_q[0] <= in_valid;
      for (int k = 1; k < NUM_W; k++) begin
        valid_q[k] <= valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < NUM_W; k++) begin
        for (int l = 0; l < LANES; l++) begin
          rem_q[k][l] <= ge[k][l] ? diff[k][l][DEN_W-1:0] : cand[k][l][DEN_W-1:0];
          acc_q[k][l] <= {acc_i[k][l][NUM_W-2:0], ge[k][l]};
        end
        den_q[k]  <= den_i[k];
        side_q[k] <= side_i[k];
      end
    end
  end

  assign out_valid       = valid_q[NUM_W-1];
  assign out_result.q_z  = acc_q[NUM_W-1][0];
  assign out_result.q_x  = acc_q[NUM_W-1][1];
  assign out_result.q_y  = acc_q[NUM_W-1][2];
  assign out_result.side = side_q[NUM_W-1];

endmodule
`default_nettype wire

// ----- hdl/smt_checker.sv -----
`default_nettype none
module smt_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            match_stall,
  input wire logic            point_valid,
  input wire logic            point_stall,
  input wire smt_pkg::point_t point
);
  import smt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    point_valid && point_stall |=> point_valid && $stable(point))
    else $error("point word changed under stall");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    match_stall |-> point_valid && point_stall)
    else $error("match stalled without output backpressure");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    point_valid && point.verdict != VERDICT_KEPT |->
      point.point_x == 32'sd0 && point.point_y == 32'sd0 && point.point_z == 30'd0)
    else $error("rejected point carries coordinates");

  a_verdict: assert property (@(posedge clk) disable iff (rst)
    point_valid |-> point.verdict == VERDICT_KEPT || point.verdict == VERDICT_VERT
                    || point.verdict == VERDICT_DEPTH)
    else $error("undefined verdict code");

endmodule

bind stereo_match_triangulate_unit smt_checker u_smt_checker (
  .clk        (clk),
  .rst        (rst),
  .match_stall(match_stall),
  .point_valid(point_valid),
  .point_stall(point_stall),
  .point      (point)
);
`default_nettype wire
